[src/csc_pkg.sv]
// Shared types and constants for the camera scaler setup calculator.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package csc_pkg;

    // Fixed field widths
    localparam int LINE_BYTES_W = 15;
    localparam int RATIO_W      = 6;
    localparam int SHIFT_W      = 3;
    localparam int SF_W         = 4;
    localparam int QUOT_W       = 9;
    localparam int FRAC_BITS    = 8;
    localparam int BURST_W      = 5;

    // Prescale limits: largest prescale shift, and the shift at which a ratio is out of range
    localparam int PRE_SHIFT_MAX = 5;
    localparam int OOR_SHIFT     = 6;

    // Shift factor base
    localparam logic [SF_W-1:0] SHIFT_BASE = 4'd10;

    // DMA burst lengths in words
    localparam logic [BURST_W-1:0] BURST_4  = 5'd4;
    localparam logic [BURST_W-1:0] BURST_8  = 5'd8;
    localparam logic [BURST_W-1:0] BURST_16 = 5'd16;

    // Width of the result fields that do not follow the size width
    localparam int OUT_FIXED_W = 2*RATIO_W + SF_W + 2*QUOT_W + 1 + 2*BURST_W;

    // Front-to-back queue depth and pointer width
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    // Classification of one request, made by the front end
    typedef struct packed {
        logic               oor;
        logic               scale_up;
        logic [SHIFT_W-1:0] hshift;
        logic [SHIFT_W-1:0] vshift;
        logic [BURST_W-1:0] body_burst;
        logic [BURST_W-1:0] last_burst;
    } csc_ctrl_t;

    localparam int CTRL_W = $bits(csc_ctrl_t);

endpackage

[src/csc_front.sv]
// Front end: takes request beats, picks prescale shifts, range flag and bursts.
// Depends on csc_pkg; feeds csc_queue.
`timescale 1ns / 1ps

module csc_front
    import csc_pkg::*;
#(
    parameter int SIZE_BITS = 13
) (
    input  logic                                       s_axis_tvalid,
    output logic                                       s_axis_tready,
    // source_width, source_height, target_width, target_height, line_bytes, zero fill
    input  logic [((4*SIZE_BITS+LINE_BYTES_W+7)/8)*8-1:0] s_axis_tdata,
    input  logic                                       q_full,
    output logic                                       push,
    output csc_ctrl_t                                  push_ctrl,
    // source_width, source_height, target_width, target_height
    output logic [4*SIZE_BITS-1:0]                     push_size
);

    localparam int EXT_W = SIZE_BITS + OOR_SHIFT;

    logic [SIZE_BITS-1:0]    src_w;
    logic [SIZE_BITS-1:0]    src_h;
    logic [SIZE_BITS-1:0]    tar_w;
    logic [SIZE_BITS-1:0]    tar_h;
    logic [LINE_BYTES_W-1:0] line_bytes;
    logic [LINE_BYTES_W-3:0] words;
    logic [SHIFT_W:0]        pick_h;
    logic [SHIFT_W:0]        pick_v;

    // Returns {out_of_range, shift} for one axis
    function automatic logic [SHIFT_W:0] pick_prescale(
        input logic [SIZE_BITS-1:0] src,
        input logic [SIZE_BITS-1:0] tar
    );
        logic [EXT_W-1:0]   s_ext;
        logic [EXT_W-1:0]   t_ext;
        logic [SHIFT_W-1:0] shift;
        logic               oor;
        s_ext = EXT_W'(src);
        t_ext = EXT_W'(tar);
        oor   = (s_ext >= (t_ext << OOR_SHIFT));
        shift = '0;
        // Largest shift whose scaled target still fits in the source
        for (int k = 1; k <= PRE_SHIFT_MAX; k++) begin
            if (s_ext >= (t_ext << k)) begin
                shift = SHIFT_W'(k);
            end
        end
        return {oor, shift};
    endfunction

    // Unpack the request
    assign src_w      = s_axis_tdata[0*SIZE_BITS +: SIZE_BITS];
    assign src_h      = s_axis_tdata[1*SIZE_BITS +: SIZE_BITS];
    assign tar_w      = s_axis_tdata[2*SIZE_BITS +: SIZE_BITS];
    assign tar_h      = s_axis_tdata[3*SIZE_BITS +: SIZE_BITS];
    assign line_bytes = s_axis_tdata[4*SIZE_BITS +: LINE_BYTES_W];
    assign words      = line_bytes[LINE_BYTES_W-1:2];

    // Accept whenever the queue has room
    assign s_axis_tready = !q_full;
    assign push          = s_axis_tvalid && !q_full;
    assign push_size     = {tar_h, tar_w, src_h, src_w};

    assign pick_h = pick_prescale(src_w, tar_w);
    assign pick_v = pick_prescale(src_h, tar_h);

    // Classify the request
    always_comb begin
        push_ctrl.oor      = pick_h[SHIFT_W] || pick_v[SHIFT_W];
        push_ctrl.scale_up = (tar_w >= src_w);
        push_ctrl.hshift   = pick_h[SHIFT_W-1:0];
        push_ctrl.vshift   = pick_v[SHIFT_W-1:0];
        priority if (words[3:0] == 4'd0) begin
            push_ctrl.body_burst = BURST_16;
            push_ctrl.last_burst = BURST_16;
        end else if (words[3:0] == 4'd4) begin
            push_ctrl.body_burst = BURST_16;
            push_ctrl.last_burst = BURST_4;
        end else if (words[3:0] == 4'd8) begin
            push_ctrl.body_burst = BURST_16;
            push_ctrl.last_burst = BURST_8;
        end else if (words[2:0] == 3'd0) begin
            push_ctrl.body_burst = BURST_8;
            push_ctrl.last_burst = BURST_8;
        end else if (words[2:0] == 3'd4) begin
            push_ctrl.body_burst = BURST_8;
            push_ctrl.last_burst = BURST_4;
        end else if (words[1:0] == 2'd0) begin
            push_ctrl.body_burst = BURST_4;
            push_ctrl.last_burst = BURST_4;
        end else begin
            push_ctrl.body_burst = BURST_4;
            push_ctrl.last_burst = BURST_W'(words[1:0]);
        end
    end

endmodule

[src/csc_queue.sv]
// Two-entry queue between the front end and the compute back end.
// Depends on csc_pkg for depth and pointer width.
`timescale 1ns / 1ps

module csc_queue
    import csc_pkg::*;
#(
    parameter int DATA_W = 70
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] din,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] dout,
    output logic              not_empty
);

    logic [DATA_W-1:0] mem_reg [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign dout      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

[src/csc_back.sv]
// Back end: setup stage, bit-per-stage ratio divider, area product, result register.
// Depends on csc_pkg; fed by csc_queue.
`timescale 1ns / 1ps

module csc_back
    import csc_pkg::*;
#(
    parameter int SIZE_BITS = 13
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          q_valid,
    output logic                                          q_pop,
    input  csc_ctrl_t                                     q_ctrl,
    // source_width, source_height, target_width, target_height
    input  logic [4*SIZE_BITS-1:0]                        q_size,
    output logic                                          m_axis_tvalid,
    input  logic                                          m_axis_tready,
    // pre_hor_ratio, pre_ver_ratio, shift_factor, pre_dst_width, pre_dst_height,
    // main_hor_ratio, main_ver_ratio, scale_up, body_burst, tail_burst,
    // target_area, zero fill
    output logic [((4*SIZE_BITS+OUT_FIXED_W+7)/8)*8-1:0] m_axis_tdata,
    // out_of_range
    output logic                                          m_axis_tuser
);

    localparam int NUM_W    = SIZE_BITS + FRAC_BITS;
    localparam int DEN_W    = SIZE_BITS + PRE_SHIFT_MAX;
    localparam int CMP_W    = DEN_W + QUOT_W - 1;
    localparam int AREA_W   = 2 * SIZE_BITS;
    localparam int M_DATA_W = ((4*SIZE_BITS+OUT_FIXED_W+7)/8)*8;

    logic [SIZE_BITS-1:0] src_w;
    logic [SIZE_BITS-1:0] src_h;
    logic [SIZE_BITS-1:0] tar_w;
    logic [SIZE_BITS-1:0] tar_h;
    logic                 en;

    // Pipeline stage registers: stage 0 is setup, stage j+1 holds quotient bits QUOT_W-1 down to QUOT_W-1-j
    logic [QUOT_W:0]      val_reg;
    csc_ctrl_t            ctrl_reg  [0:QUOT_W];
    logic [SIZE_BITS-1:0] pdw_reg   [0:QUOT_W];
    logic [SIZE_BITS-1:0] pdh_reg   [0:QUOT_W];
    logic [AREA_W-1:0]    area_reg  [0:QUOT_W];
    logic [NUM_W-1:0]     rem_h_reg [0:QUOT_W];
    logic [NUM_W-1:0]     rem_v_reg [0:QUOT_W];
    logic [DEN_W-1:0]     den_h_reg [0:QUOT_W];
    logic [DEN_W-1:0]     den_v_reg [0:QUOT_W];
    logic [QUOT_W-1:0]    quo_h_reg [0:QUOT_W];
    logic [QUOT_W-1:0]    quo_v_reg [0:QUOT_W];

    logic [CMP_W:0]       diff_h     [0:QUOT_W-1];
    logic [CMP_W:0]       diff_v     [0:QUOT_W-1];
    logic [NUM_W-1:0]     rem_h_next [0:QUOT_W-1];
    logic [NUM_W-1:0]     rem_v_next [0:QUOT_W-1];
    logic [QUOT_W-1:0]    quo_h_next [0:QUOT_W-1];
    logic [QUOT_W-1:0]    quo_v_next [0:QUOT_W-1];

    csc_ctrl_t            last_ctrl;
    logic [RATIO_W-1:0]   ratio_h;
    logic [RATIO_W-1:0]   ratio_v;
    logic [SF_W-1:0]      shift_factor;
    logic                 m_tvalid_reg;
    logic [M_DATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic                 m_tuser_reg, m_tuser_next;

    assign src_w = q_size[0*SIZE_BITS +: SIZE_BITS];
    assign src_h = q_size[1*SIZE_BITS +: SIZE_BITS];
    assign tar_w = q_size[2*SIZE_BITS +: SIZE_BITS];
    assign tar_h = q_size[3*SIZE_BITS +: SIZE_BITS];

    // Whole pipeline holds while the result register is stalled
    assign en    = !m_tvalid_reg || m_axis_tready;
    assign q_pop = en && q_valid;

    // One quotient bit per stage, both axes side by side
    always_comb begin
        for (int j = 0; j < QUOT_W; j++) begin
            diff_h[j] = {1'b0, CMP_W'(rem_h_reg[j])}
                      - {1'b0, (CMP_W'(den_h_reg[j]) << (QUOT_W-1-j))};
            diff_v[j] = {1'b0, CMP_W'(rem_v_reg[j])}
                      - {1'b0, (CMP_W'(den_v_reg[j]) << (QUOT_W-1-j))};
            rem_h_next[j] = diff_h[j][CMP_W] ? rem_h_reg[j] : diff_h[j][NUM_W-1:0];
            rem_v_next[j] = diff_v[j][CMP_W] ? rem_v_reg[j] : diff_v[j][NUM_W-1:0];
            quo_h_next[j] = {quo_h_reg[j][QUOT_W-2:0], ~diff_h[j][CMP_W]};
            quo_v_next[j] = {quo_v_reg[j][QUOT_W-2:0], ~diff_v[j][CMP_W]};
        end
    end

    // Stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val_reg <= '0;
        end else if (en) begin
            val_reg <= {val_reg[QUOT_W-1:0], q_valid};
        end
    end

    // Stage payload: setup from the queue head, then divider steps
    always_ff @(posedge aclk) begin
        if (en) begin
            ctrl_reg[0]  <= q_ctrl;
            pdw_reg[0]   <= src_w >> q_ctrl.hshift;
            pdh_reg[0]   <= src_h >> q_ctrl.vshift;
            area_reg[0]  <= AREA_W'(tar_w) * AREA_W'(tar_h);
            rem_h_reg[0] <= {src_w, {FRAC_BITS{1'b0}}};
            rem_v_reg[0] <= {src_h, {FRAC_BITS{1'b0}}};
            den_h_reg[0] <= DEN_W'(tar_w) << q_ctrl.hshift;
            den_v_reg[0] <= DEN_W'(tar_h) << q_ctrl.vshift;
            quo_h_reg[0] <= '0;
            quo_v_reg[0] <= '0;
            for (int j = 0; j < QUOT_W; j++) begin
                ctrl_reg[j+1]  <= ctrl_reg[j];
                pdw_reg[j+1]   <= pdw_reg[j];
                pdh_reg[j+1]   <= pdh_reg[j];
                area_reg[j+1]  <= area_reg[j];
                rem_h_reg[j+1] <= rem_h_next[j];
                rem_v_reg[j+1] <= rem_v_next[j];
                den_h_reg[j+1] <= den_h_reg[j];
                den_v_reg[j+1] <= den_v_reg[j];
                quo_h_reg[j+1] <= quo_h_next[j];
                quo_v_reg[j+1] <= quo_v_next[j];
            end
        end
    end

    // Pack the result; drop every field to zero when out of range
    assign last_ctrl    = ctrl_reg[QUOT_W];
    assign ratio_h      = RATIO_W'(1) << last_ctrl.hshift;
    assign ratio_v      = RATIO_W'(1) << last_ctrl.vshift;
    assign shift_factor = SHIFT_BASE - SF_W'(last_ctrl.hshift) - SF_W'(last_ctrl.vshift);

    always_comb begin
        m_tuser_next = last_ctrl.oor;
        if (last_ctrl.oor) begin
            m_tdata_next = '0;
        end else begin
            m_tdata_next = M_DATA_W'({area_reg[QUOT_W], last_ctrl.last_burst,
                                      last_ctrl.body_burst, last_ctrl.scale_up,
                                      quo_v_reg[QUOT_W], quo_h_reg[QUOT_W],
                                      pdh_reg[QUOT_W], pdw_reg[QUOT_W],
                                      shift_factor, ratio_v, ratio_h});
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= val_reg[QUOT_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

endmodule

[src/camera_scaler_setup_calc.sv]
// Top level of the camera scaler setup calculator: front end, queue, back end.
// Depends on csc_pkg, csc_front, csc_queue and csc_back.
//
//   Channel  Dir  Beat carries
//   s_axis   in   source_width, source_height, target_width, target_height, line_bytes
//   m_axis   out  prescale ratios, shift factor, prescaled sizes, main ratios,
//                 scale_up, bursts, target_area; tuser = out_of_range
//
// One request per cycle sustained while the result is not stalled; after
// acceptance the setup stage takes a request from the queue, nine divider
// stages (one quotient bit each) follow, then the result register.
// Reset empties the queue and clears all stage valid bits.
// A stalled result holds the whole back end; the two-entry queue keeps taking
// requests until it fills, then s_axis_tready drops.
`timescale 1ns / 1ps

module camera_scaler_setup_calc
    import csc_pkg::*;
#(
    parameter int SIZE_BITS = 13
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          s_axis_tvalid,
    output logic                                          s_axis_tready,
    // source_width, source_height, target_width, target_height, line_bytes, zero fill
    input  logic [((4*SIZE_BITS+LINE_BYTES_W+7)/8)*8-1:0] s_axis_tdata,
    output logic                                          m_axis_tvalid,
    input  logic                                          m_axis_tready,
    // pre_hor_ratio, pre_ver_ratio, shift_factor, pre_dst_width, pre_dst_height,
    // main_hor_ratio, main_ver_ratio, scale_up, body_burst, tail_burst,
    // target_area, zero fill
    output logic [((4*SIZE_BITS+OUT_FIXED_W+7)/8)*8-1:0] m_axis_tdata,
    // out_of_range
    output logic                                          m_axis_tuser
);

    localparam int SIZE_W  = 4 * SIZE_BITS;
    localparam int ENTRY_W = CTRL_W + SIZE_W;

    logic                 push;
    csc_ctrl_t            push_ctrl;
    logic [SIZE_W-1:0]    push_size;
    logic                 q_full;
    logic                 q_valid;
    logic                 q_pop;
    logic [ENTRY_W-1:0]   q_dout;
    csc_ctrl_t            q_ctrl;
    logic [SIZE_W-1:0]    q_size;

    csc_front #(
        .SIZE_BITS(SIZE_BITS)
    ) u_front (
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .q_full       (q_full),
        .push         (push),
        .push_ctrl    (push_ctrl),
        .push_size    (push_size)
    );

    csc_queue #(
        .DATA_W(ENTRY_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .din      ({push_ctrl, push_size}),
        .full     (q_full),
        .pop      (q_pop),
        .dout     (q_dout),
        .not_empty(q_valid)
    );

    // Split the queue head back into classification and sizes
    assign q_ctrl = csc_ctrl_t'(q_dout[ENTRY_W-1 -: CTRL_W]);
    assign q_size = q_dout[SIZE_W-1:0];

    csc_back #(
        .SIZE_BITS(SIZE_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_ctrl       (q_ctrl),
        .q_size       (q_size),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

endmodule

[src/csc_checker.sv]
// Port-level checks on the result channel of the scaler setup calculator.
// Depends on csc_pkg; bound to camera_scaler_setup_calc.
`timescale 1ns / 1ps

module csc_checker
    import csc_pkg::*;
#(
    parameter int SIZE_BITS = 13
) (
    input logic                                          aclk,
    input logic                                          aresetn,
    input logic                                          m_axis_tvalid,
    input logic                                          m_axis_tready,
    input logic [((4*SIZE_BITS+OUT_FIXED_W+7)/8)*8-1:0] m_axis_tdata,
    input logic                                          m_axis_tuser
);

    localparam int MB_LO = 2*RATIO_W + SF_W + 2*SIZE_BITS + 2*QUOT_W + 1;

    // A stalled beat stays
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // A stalled beat keeps its payload
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result payload changed while stalled");

    // Out-of-range results carry all-zero fields
    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("out-of-range result with nonzero fields");

    // Valid results have power-of-two prescale ratios on both axes
    a_ratio_pow2: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |->
            $onehot(m_axis_tdata[RATIO_W-1:0]) && $onehot(m_axis_tdata[2*RATIO_W-1:RATIO_W]))
        else $error("prescale ratio not a power of two");

    // Valid results have a main burst of 4, 8 or 16 words
    a_main_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |->
            m_axis_tdata[MB_LO +: BURST_W] == BURST_4 ||
            m_axis_tdata[MB_LO +: BURST_W] == BURST_8 ||
            m_axis_tdata[MB_LO +: BURST_W] == BURST_16)
        else $error("main burst length not 4, 8 or 16");

endmodule

bind camera_scaler_setup_calc csc_checker #(
    .SIZE_BITS(SIZE_BITS)
) u_csc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);
